[src/mcr_pkg.sv]
package mcr_pkg;

    // Field widths of the stream items
    localparam int unsigned CoordW  = 11;
    localparam int unsigned RadiusW = 10;
    localparam int unsigned ColorW  = 4;
    localparam int unsigned PixelW  = 13;
    localparam int unsigned DecW    = 14;

    // Largest radius taken; larger requests saturate to it
    localparam logic [RadiusW-1:0] MaxRadius = RadiusW'(1023);

    // Input kinds carried on s_tuser
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // One step's worth of work handed from the front to the back.
    // off_y is two's complement with one extra bit: a zero radius steps it to -1.
    typedef struct packed {
        logic [CoordW-1:0]  center_x;
        logic [CoordW-1:0]  center_y;
        logic [ColorW-1:0]  color;
        logic [RadiusW-1:0] off_x;
        logic [RadiusW:0]   off_y;
        logic               done;
    } group_t;

    // Octant mirror: swap the offsets, then negate either axis
    typedef struct packed {
        logic swap;
        logic neg_x;
        logic neg_y;
    } mirror_t;

    // Order: (x,y) (y,x) (-x,y) (x,-y) (-x,-y) (-y,-x) (y,-x) (-y,x)
    localparam mirror_t MirrorTab [8] = '{
        '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0},
        '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0},
        '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0},
        '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1},
        '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1},
        '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1},
        '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1},
        '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0}
    };

endpackage

[src/mcr_front.sv]
module mcr_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic                             in_mode,
    input  logic [mcr_pkg::CoordW-1:0]       in_center_x,
    input  logic [mcr_pkg::CoordW-1:0]       in_center_y,
    input  logic [mcr_pkg::RadiusW-1:0]      in_radius,
    input  logic [mcr_pkg::ColorW-1:0]       in_color,
    output logic                             push,
    output mcr_pkg::group_t                  push_group,
    input  logic                             queue_full
);

    logic [mcr_pkg::RadiusW-1:0] x_reg, x_next;
    logic [mcr_pkg::RadiusW:0]   y_reg, y_next;
    logic [mcr_pkg::DecW-1:0]    dec_reg, dec_next;
    logic [mcr_pkg::CoordW-1:0]  cx_reg, cx_next;
    logic [mcr_pkg::CoordW-1:0]  cy_reg, cy_next;
    logic [mcr_pkg::ColorW-1:0]  color_reg, color_next;
    logic                        active_reg, active_next;

    logic                        accept;
    logic [mcr_pkg::RadiusW-1:0] r_sat;
    logic [mcr_pkg::DecW-1:0]    x_ext, y_ext, dec_diff, dec_inc;
    logic                        step_done;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign r_sat    = (in_radius > mcr_pkg::MaxRadius) ? mcr_pkg::MaxRadius : in_radius;
    assign x_ext    = {{(mcr_pkg::DecW-mcr_pkg::RadiusW){1'b0}}, x_reg};
    assign y_ext    = {{(mcr_pkg::DecW-mcr_pkg::RadiusW-1){y_reg[mcr_pkg::RadiusW]}}, y_reg};
    assign dec_diff = x_ext - y_ext;

    always_comb begin
        x_next      = x_reg;
        y_next      = y_reg;
        dec_next    = dec_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        color_next  = color_reg;
        active_next = active_reg;
        push        = 1'b0;
        step_done   = 1'b0;
        dec_inc     = '0;
        if (accept) begin
            if (in_mode == mcr_pkg::MODE_START) begin
                // Latch the circle and place the pen at the top
                cx_next     = in_center_x;
                cy_next     = in_center_y;
                color_next  = in_color;
                x_next      = '0;
                y_next      = {1'b0, r_sat};
                dec_next    = mcr_pkg::DecW'(1)
                              - {{(mcr_pkg::DecW-mcr_pkg::RadiusW){1'b0}}, r_sat};
                active_next = 1'b1;
                push        = 1'b1;
            end else if (active_reg) begin
                if (dec_reg[mcr_pkg::DecW-1]) begin
                    dec_inc = {x_ext[mcr_pkg::DecW-2:0], 1'b0} + mcr_pkg::DecW'(3);
                end else begin
                    dec_inc = {dec_diff[mcr_pkg::DecW-2:0], 1'b0} + mcr_pkg::DecW'(5);
                    y_next  = y_reg - (mcr_pkg::RadiusW+1)'(1);
                end
                dec_next    = dec_reg + dec_inc;
                x_next      = x_reg + mcr_pkg::RadiusW'(1);
                step_done   = ($signed({1'b0, x_next}) > $signed(y_next));
                active_next = !step_done;
                push        = 1'b1;
            end
        end
    end

    always_comb begin
        push_group.center_x = cx_next;
        push_group.center_y = cy_next;
        push_group.color    = color_next;
        push_group.off_x    = x_next;
        push_group.off_y    = y_next;
        push_group.done     = step_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg      <= '0;
            y_reg      <= '0;
            dec_reg    <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            color_reg  <= '0;
            active_reg <= 1'b0;
        end else begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            dec_reg    <= dec_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            color_reg  <= color_next;
            active_reg <= active_next;
        end
    end

endmodule

[src/mcr_queue.sv]
module mcr_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mcr_pkg::group_t push_group,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output mcr_pkg::group_t head_group
);

    // Two entries, head shown ahead of the pop
    mcr_pkg::group_t  slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_group = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_group;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/mcr_back.sv]
module mcr_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             head_valid,
    input  mcr_pkg::group_t                  head_group,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mcr_pkg::PixelW-1:0]       out_x,
    output logic [mcr_pkg::PixelW-1:0]       out_y,
    output logic [mcr_pkg::ColorW-1:0]       out_color,
    output logic                             out_last,
    output logic                             out_done
);

    logic [2:0]                  idx_reg, idx_next;
    logic                        valid_reg, valid_next;
    logic [mcr_pkg::PixelW-1:0]  px_reg, px_next;
    logic [mcr_pkg::PixelW-1:0]  py_reg, py_next;
    logic [mcr_pkg::ColorW-1:0]  color_reg;
    logic                        last_reg, last_next;
    logic                        done_reg;

    logic                        load;
    mcr_pkg::mirror_t            mir;
    logic [mcr_pkg::RadiusW:0]   mag_x, mag_y;
    logic [mcr_pkg::PixelW-1:0]  ext_x, ext_y, base_x, base_y;

    assign load = head_valid && (!valid_reg || m_tready);
    assign pop  = load && (idx_reg == 3'd7);
    assign mir  = mcr_pkg::MirrorTab[idx_reg];

    always_comb begin
        // Offsets are signed: off_x is never negative, off_y may be -1
        mag_x  = mir.swap ? head_group.off_y : {1'b0, head_group.off_x};
        mag_y  = mir.swap ? {1'b0, head_group.off_x} : head_group.off_y;
        ext_x  = {{(mcr_pkg::PixelW-mcr_pkg::RadiusW-1){mag_x[mcr_pkg::RadiusW]}}, mag_x};
        ext_y  = {{(mcr_pkg::PixelW-mcr_pkg::RadiusW-1){mag_y[mcr_pkg::RadiusW]}}, mag_y};
        base_x = {{(mcr_pkg::PixelW-mcr_pkg::CoordW){1'b0}}, head_group.center_x};
        base_y = {{(mcr_pkg::PixelW-mcr_pkg::CoordW){1'b0}}, head_group.center_y};
        px_next = mir.neg_x ? (base_x - ext_x) : (base_x + ext_x);
        py_next = mir.neg_y ? (base_y - ext_y) : (base_y + ext_y);
        last_next = (idx_reg == 3'd7);
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = idx_reg + 3'd1;
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            color_reg <= head_group.color;
            done_reg  <= last_next && head_group.done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            if (load) begin
                last_reg <= last_next;
            end
        end
    end

    assign m_tvalid  = valid_reg;
    assign out_x     = px_reg;
    assign out_y     = py_reg;
    assign out_color = color_reg;
    assign out_last  = last_reg;
    assign out_done  = done_reg;

endmodule

[src/midpoint_circle_rasterizer_top.sv]
// A group's first pixel reaches m_tdata through the group queue and then the pixel unit's
// output register, which loads once the output is free or m_tready is high.
// Throughput: one pixel per cycle while m_tready stays high, eight pixels for each start
// or active advance, set by the pixel unit's walk over the eight mirrors; idle advances push none.
// A two-entry group queue lets the step logic take the next item meanwhile.
// Reset: aresetn synchronous, active low; clears queue, output valid and circle state.
module midpoint_circle_rasterizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // center_x[10:0], center_y[21:11], radius[31:22],
                                   // pen_color[35:32], zero pad[39:36]
    input  logic        s_tuser,   // mode: 0 start, 1 advance
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_x[12:0], pixel_y[25:13], pixel_color[29:26],
                                   // zero pad[31:30]
    output logic        m_tlast,   // last_of_step
    output logic        m_tuser    // circle_done
);

    // Front to queue
    logic            push;
    mcr_pkg::group_t push_group;
    logic            queue_full;

    // Queue to back
    logic            pop;
    logic            head_valid;
    mcr_pkg::group_t head_group;

    logic [mcr_pkg::PixelW-1:0] pix_x;
    logic [mcr_pkg::PixelW-1:0] pix_y;
    logic [mcr_pkg::ColorW-1:0] pix_color;

    // Step logic: decode each transfer, latch a start or run one midpoint step on an advance,
    // hand the resulting position to the queue; drop advances while idle
    mcr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .in_mode     (s_tuser),
        .in_center_x (s_tdata[10:0]),
        .in_center_y (s_tdata[21:11]),
        .in_radius   (s_tdata[31:22]),
        .in_color    (s_tdata[35:32]),
        .push        (push),
        .push_group  (push_group),
        .queue_full  (queue_full)
    );

    // Hold up to two pending groups so both sides stall independently
    mcr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_group (push_group),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_group (head_group)
    );

    // Pixel unit: walk the eight octant mirrors of the head group, one
    // registered pixel per transfer
    mcr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_group (head_group),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_x      (pix_x),
        .out_y      (pix_y),
        .out_color  (pix_color),
        .out_last   (m_tlast),
        .out_done   (m_tuser)
    );

    assign m_tdata = {2'b00, pix_color, pix_y, pix_x};

endmodule

[test/tb_midpoint_circle_rasterizer_top.sv]
module tb_midpoint_circle_rasterizer_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mcr_pkg::*;

    // One pixel as it should leave the block
    typedef struct {
        logic [PixelW-1:0] px;
        logic [PixelW-1:0] py;
        logic [ColorW-1:0] color;
        logic              last;
        logic              done;
    } pixel_t;

    // Tracks the circle in progress and holds the pixels still owed by the block
    class circle_pixel_scoreboard;
        int                off_x;
        int                off_y;
        int                decision;
        logic [CoordW-1:0] cx;
        logic [CoordW-1:0] cy;
        logic [ColorW-1:0] pen;
        bit                active;
        pixel_t            pixels_due[$];
        int                n_errors;
        int                n_starts;
        int                n_steps;
        int                n_ignored;
        int                n_finished;
        int                n_pixels;

        // Queue the eight mirrored pixels of the current offset
        function void queue_octants(bit done);
            int     dx[8];
            int     dy[8];
            pixel_t p;
            dx = '{off_x, off_y, -off_x, off_x, -off_x, -off_y, off_y, -off_y};
            dy = '{off_y, off_x, off_y, -off_y, -off_y, -off_x, -off_x, off_x};
            for (int k = 0; k < 8; k++) begin
                p.px    = PixelW'(int'(cx) + dx[k]);
                p.py    = PixelW'(int'(cy) + dy[k]);
                p.color = pen;
                p.last  = (k == 7);
                p.done  = (k == 7) && done;
                pixels_due.push_back(p);
            end
        endfunction

        // Note one accepted input transfer
        function void take_item(logic mode, logic [CoordW-1:0] x_in, logic [CoordW-1:0] y_in,
                                logic [RadiusW-1:0] r_in, logic [ColorW-1:0] pen_in);
            logic [RadiusW-1:0] r;
            bit                 done;
            if (mode == MODE_START) begin
                r        = (r_in > MaxRadius) ? MaxRadius : r_in;
                cx       = x_in;
                cy       = y_in;
                pen      = pen_in;
                off_x    = 0;
                off_y    = int'(r);
                decision = 1 - int'(r);
                active   = 1'b1;
                n_starts++;
                queue_octants(1'b0);
            end else if (!active) begin
                n_ignored++;
            end else begin
                if (decision < 0) begin
                    decision += 2 * off_x + 3;
                end else begin
                    decision += 2 * (off_x - off_y) + 5;
                    off_y--;
                end
                off_x++;
                done = (off_x > off_y);
                if (done) begin
                    active = 1'b0;
                    n_finished++;
                end
                n_steps++;
                queue_octants(done);
            end
        endfunction

        // Compare one accepted output transfer with the oldest pixel owed
        function void match_pixel(logic [31:0] data, logic last, logic done);
            pixel_t want;
            if (pixels_due.size() == 0) begin
                $error("pixel (%0d,%0d) with no pixel owed",
                       $signed(data[PixelW-1:0]), $signed(data[2*PixelW-1:PixelW]));
                n_errors++;
                return;
            end
            want = pixels_due.pop_front();
            n_pixels++;
            if (data[PixelW-1:0] !== want.px) begin
                $error("pixel_x: expected %0d, got %0d",
                       $signed(want.px), $signed(data[PixelW-1:0]));
                n_errors++;
            end
            if (data[2*PixelW-1:PixelW] !== want.py) begin
                $error("pixel_y: expected %0d, got %0d",
                       $signed(want.py), $signed(data[2*PixelW-1:PixelW]));
                n_errors++;
            end
            if (data[2*PixelW+ColorW-1:2*PixelW] !== want.color) begin
                $error("pixel_color: expected %0d, got %0d",
                       want.color, data[2*PixelW+ColorW-1:2*PixelW]);
                n_errors++;
            end
            if (last !== want.last) begin
                $error("last_of_step: expected %0b, got %0b", want.last, last);
                n_errors++;
            end
            if (done !== want.done) begin
                $error("circle_done: expected %0b, got %0b", want.done, done);
                n_errors++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // center_x[10:0], center_y[21:11], radius[31:22],
                                  // pen_color[35:32], zero pad[39:36]
    logic        s_tuser  = 1'b0; // mode: 0 start, 1 advance
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // pixel_x[12:0], pixel_y[25:13], pixel_color[29:26],
                                  // zero pad[31:30]
    logic        m_tlast;         // last_of_step
    logic        m_tuser;         // circle_done

    // Idle odds in percent for each side, and a long receiver hold-off in cycles
    int unsigned tx_idle_pct = 35;
    int unsigned rx_idle_pct = 83;
    int unsigned hold_left   = 0;

    circle_pixel_scoreboard circle_sb = new();

    midpoint_circle_rasterizer_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver: hold off for the requested stretch, otherwise stall at random
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Inputs only move at rising edges, so the mid-cycle view shows exactly
    // what the next edge will see: a pixel seen here is a transfer at that edge.
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            circle_sb.match_pixel(m_tdata, m_tlast, m_tuser);
        end
    end

    // Offer one item, wait for its transfer, then note it for prediction.
    // Leave tvalid high on return so back-to-back items stay back to back.
    task automatic send_item(input logic mode, input logic [CoordW-1:0] x_in,
                             input logic [CoordW-1:0] y_in, input logic [RadiusW-1:0] r_in,
                             input logic [ColorW-1:0] pen_in);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0000, pen_in, r_in, y_in, x_in};
        forever begin
            @(negedge aclk);
            if (s_tready) break;
        end
        @(posedge aclk);
        circle_sb.take_item(mode, x_in, y_in, r_in, pen_in);
    endtask

    // Advance with random content in the fields the block ignores
    task automatic advance_step();
        send_item(MODE_ADVANCE, CoordW'($urandom), CoordW'($urandom),
                  RadiusW'($urandom), ColorW'($urandom));
    endtask

    // Mostly whole circles of small radius; some cut short by a fresh start,
    // a few with any radius, and stray advances after the circle has ended.
    task automatic random_circles(input int quota);
        int accepted;
        int pick;
        int r;
        int steps_left;
        accepted = 0;
        while (accepted < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                r = $urandom_range(0, 12);
            end else if (pick < 90) begin
                r = $urandom_range(13, 60);
            end else begin
                r = $urandom_range(0, 1023);
            end
            steps_left = (r > 60 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 4096;
            send_item(MODE_START, CoordW'($urandom), CoordW'($urandom), RadiusW'(r),
                      ColorW'($urandom));
            accepted++;
            while (circle_sb.active && steps_left > 0 && accepted < quota) begin
                advance_step();
                accepted++;
                steps_left--;
            end
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 2)) advance_step();
            end
        end
    endtask

    initial begin
        // Hold reset, then release it once
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: advance straight out of reset, with every field bit set
        send_item(MODE_ADVANCE, '1, '1, '1, '1);
        // Zero radius at the origin: eight pixels at the centre, then one step ends it
        send_item(MODE_START, '0, '0, '0, 4'd15);
        advance_step();
        // Circle already finished: drop this advance
        advance_step();
        // Largest radius at the far corner, drawn in the erase colour
        send_item(MODE_START, '1, '1, MaxRadius, 4'd0);
        repeat (2) advance_step();
        // Restart while active: abandon the corner circle, go negative at the origin
        send_item(MODE_START, '0, '0, MaxRadius, 4'd15);
        repeat (2) advance_step();
        // Radius one and two, run to completion; the extra advance is ignored
        send_item(MODE_START, 11'd1024, 11'd5, 10'd1, 4'd7);
        while (circle_sb.active) advance_step();
        advance_step();
        send_item(MODE_START, 11'd100, 11'd2000, 10'd2, 4'd0);
        while (circle_sb.active) advance_step();

        // Random: slow receiver, then slow sender, then no idling at all
        random_circles(170);
        tx_idle_pct = 83;
        rx_idle_pct = 35;
        random_circles(170);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // Hold the receiver off while the sender keeps pushing, so the group
        // queue fills and s_tready drops
        hold_left = 400;
        random_circles(160);
        s_tvalid <= 1'b0;

        // Drain the pixels still owed, then allow for a stray late transfer
        while (circle_sb.pixels_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Circles started %0d, finished %0d; midpoint steps %0d, idle advances %0d",
                 circle_sb.n_starts, circle_sb.n_finished, circle_sb.n_steps,
                 circle_sb.n_ignored);
        $display("Pixels compared %0d, mismatches %0d", circle_sb.n_pixels,
                 circle_sb.n_errors);
        if (circle_sb.n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
src/mcr_pkg.sv
src/mcr_front.sv
src/mcr_queue.sv
src/mcr_back.sv
src/midpoint_circle_rasterizer_top.sv
test/tb_midpoint_circle_rasterizer_top.sv
